// ----- rtl/core/rc_pulse_width_decoder_defines.svh -----
// Assertion macros shared by the RC pulse width decoder RTL.
`ifndef RC_PULSE_WIDTH_DECODER_DEFINES_SVH
`define RC_PULSE_WIDTH_DECODER_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define RCPWD_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Same-cycle implication.
`define RCPWD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RCPWD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/rcpwd_pkg.sv -----
// Shared types and constants for the RC pulse width decoder.
`timescale 1ns / 1ps
`default_nettype none
package rcpwd_pkg;

	localparam int unsigned CNT_W    = 16;
	localparam int unsigned VAL_W    = 8;
	localparam int unsigned NUM_W    = CNT_W + VAL_W;   // (width - low) * 180
	localparam int unsigned STEP_W   = 5;               // holds 0 .. NUM_W-1
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [VAL_W-1:0]  FULL_SCALE = 8'd180;
	localparam logic [CNT_W-1:0]  CNT_MAX    = 16'hFFFF;
	localparam logic [STEP_W-1:0] LAST_STEP  = 5'(NUM_W - 1);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FALLBACK  = 3'd4;

	typedef struct packed {
		logic [CNT_W-1:0] timeout_ticks;
		logic [CNT_W-1:0] max_valid_width;
		logic [CNT_W-1:0] span_low;
		logic [CNT_W-1:0] span_high;
		logic [VAL_W-1:0] fallback_value;
	} cfg_t;

	// Classified work item passed from front to back
	typedef struct packed {
		logic             is_div;   // value needs the divider
		logic [CNT_W-1:0] operand;  // width - span_low, or the final value
		logic [CNT_W-1:0] den;      // span_high - span_low
		logic             present;
		logic [CNT_W-1:0] width;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_LOAD,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage
`default_nettype wire

// ----- rtl/core/rcpwd_front.sv -----
// Edge tracking, pulse validation and classification of each tick.
`timescale 1ns / 1ps
`default_nettype none
module rcpwd_front
	import rcpwd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic level,
	output logic      push_valid,
	input  wire logic push_ready,
	output job_t      push_job
);

	logic             prev_q;
	logic [CNT_W-1:0] elapsed_q;
	logic [CNT_W-1:0] width_q;

	logic             rise;
	logic             fall;
	logic             accept;
	logic [CNT_W-1:0] elapsed_nxt;
	logic [CNT_W-1:0] width_nxt;
	logic             present;
	logic [VAL_W-1:0] fb;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid & push_ready;

	assign rise = level & ~prev_q;
	assign fall = ~level & prev_q;

	always_comb begin
		if (rise) begin
			elapsed_nxt = '0;
		end else if (elapsed_q == CNT_MAX) begin
			elapsed_nxt = elapsed_q;
		end else begin
			elapsed_nxt = elapsed_q + 16'd1;
		end
		width_nxt = fall ? elapsed_nxt : width_q;
	end

	assign present = (elapsed_nxt < cfg.timeout_ticks) && (width_nxt != '0) &&
		(width_nxt <= cfg.max_valid_width);
	assign fb = (cfg.fallback_value > FULL_SCALE) ? FULL_SCALE : cfg.fallback_value;

	always_comb begin
		push_job.is_div  = 1'b0;
		push_job.operand = '0;
		push_job.den     = cfg.span_high - cfg.span_low;
		push_job.present = present;
		push_job.width   = width_nxt;
		if (!present) begin
			push_job.operand = {8'd0, fb};
		end else if (cfg.span_high <= cfg.span_low || width_nxt <= cfg.span_low) begin
			push_job.operand = '0;
		end else if (width_nxt >= cfg.span_high) begin
			push_job.operand = {8'd0, FULL_SCALE};
		end else begin
			push_job.is_div  = 1'b1;
			push_job.operand = width_nxt - cfg.span_low;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= 1'b0;
			elapsed_q <= CNT_MAX;
			width_q   <= '0;
		end else if (accept) begin
			prev_q    <= level;
			elapsed_q <= elapsed_nxt;
			width_q   <= width_nxt;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/rcpwd_queue.sv -----
// Two-entry job queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
`include "rc_pulse_width_decoder_defines.svh"
module rcpwd_queue
	import rcpwd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire job_t push_job,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output job_t      pop_job
);

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`RCPWD_ASSERT(a_queue_bound, count_q != 2'd3, "queue count out of range")

endmodule
`default_nettype wire

// ----- rtl/core/rcpwd_back.sv -----
// Back end: restoring divider for the linear map and the result register.
`timescale 1ns / 1ps
`default_nettype none
`include "rc_pulse_width_decoder_defines.svh"
module rcpwd_back
	import rcpwd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pop_valid,
	output logic                   pop_ready,
	input  wire job_t              pop_job,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [VAL_W-1:0]       out_value,
	output logic                   out_present,
	output logic [CNT_W-1:0]       out_width
);

	back_state_t      state_q;
	back_state_t      state_nxt;
	logic [NUM_W-1:0] num_q;      // dividend, shifts out as quotient shifts in
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] den_q;
	logic [STEP_W-1:0] step_q;
	logic             present_q;
	logic [CNT_W-1:0] width_q;

	logic             out_valid_q;
	logic [VAL_W-1:0] out_value_q;
	logic             out_present_q;
	logic [CNT_W-1:0] out_width_q;

	logic             out_load;
	logic [CNT_W:0]   shifted;
	logic [CNT_W:0]   diff;
	logic             ge;
	logic [NUM_W-1:0] product;

	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = ~diff[CNT_W];
	assign product = NUM_W'({8'd0, num_q[CNT_W-1:0]} * {16'd0, FULL_SCALE});

	// Outputs of the sequencer
	always_comb begin
		pop_ready = (state_q == BK_IDLE);
		out_load  = (state_q == BK_DONE) && (!out_valid_q || out_ready);
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (pop_valid) begin
					state_nxt = pop_job.is_div ? BK_LOAD : BK_DONE;
				end
			end
			BK_LOAD: begin
				state_nxt = BK_DIV;
			end
			BK_DIV: begin
				if (step_q == LAST_STEP) begin
					state_nxt = BK_DONE;
				end
			end
			BK_DONE: begin
				if (out_load) begin
					state_nxt = BK_IDLE;
				end
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (pop_valid) begin
					num_q     <= {8'd0, pop_job.operand};
					den_q     <= pop_job.den;
					present_q <= pop_job.present;
					width_q   <= pop_job.width;
				end
			end
			BK_LOAD: begin
				num_q  <= product;
				rem_q  <= '0;
				step_q <= '0;
			end
			BK_DIV: begin
				rem_q  <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
				num_q  <= {num_q[NUM_W-2:0], ge};
				step_q <= step_q + 5'd1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q   <= num_q[VAL_W-1:0];
			out_present_q <= present_q;
			out_width_q   <= width_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_value   = out_value_q;
	assign out_present = out_present_q;
	assign out_width   = out_width_q;

	`RCPWD_ASSERT_IMP(a_div_den_nonzero, state_q == BK_DIV, den_q != '0,
		"divide started with a zero span")
	`RCPWD_ASSERT_IMP(a_result_in_range, out_load,
		(num_q[NUM_W-1:VAL_W] == '0) && (num_q[VAL_W-1:0] <= FULL_SCALE),
		"result exceeds full scale")
	`RCPWD_ASSERT_NXT(a_load_starts_div, state_q == BK_LOAD,
		(state_q == BK_DIV) && (step_q == '0), "divider not started after load")

endmodule
`default_nettype wire

// ----- rtl/core/rc_pulse_width_decoder.sv -----
// Top level of the RC pulse width decoder: configuration registers and stream ports.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted input transaction is one 1 us tick carrying the sampled PWM pin
// level; each gives exactly one output transaction with the mapped 0..180 value
// (or the fallback), a signal-present flag and the latest pulse width. The front
// end takes a tick per cycle into a two-entry queue while it has room; the back
// end takes a new tick only once the last one is handed on. A fixed value (invalid,
// clamped or empty span) skips the 24-step restoring divider, which otherwise
// computes (width - span_low) * 180 / (span_high - span_low). Configuration
// registers take effect immediately and must be written only while idle.
module rc_pulse_width_decoder
	import rcpwd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CNT_W-1:0]     cfg_wdata,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,   // [0] level, [7:1] zero
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [23:0]               m_tdata,   // [7:0] servo_value, [23:8] pulse_width
	output logic                      m_tuser    // [0] signal_present
);

	cfg_t cfg_q;
	logic front_valid;
	logic front_ready;
	job_t front_job;
	logic back_valid;
	logic back_ready;
	job_t back_job;
	logic [VAL_W-1:0] out_value;
	logic [CNT_W-1:0] out_width;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks   <= 16'd25000;
			cfg_q.max_valid_width <= 16'd2500;
			cfg_q.span_low        <= 16'd1000;
			cfg_q.span_high       <= 16'd2000;
			cfg_q.fallback_value  <= 8'd90;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIMEOUT:   cfg_q.timeout_ticks   <= cfg_wdata;
				REG_MAX_WIDTH: cfg_q.max_valid_width <= cfg_wdata;
				REG_SPAN_LOW:  cfg_q.span_low        <= cfg_wdata;
				REG_SPAN_HIGH: cfg_q.span_high       <= cfg_wdata;
				REG_FALLBACK:  cfg_q.fallback_value  <= cfg_wdata[VAL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rcpwd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.level      (s_tdata[0]),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_job   (front_job)
	);

	rcpwd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_job   (front_job),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_job    (back_job)
	);

	rcpwd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (back_valid),
		.pop_ready   (back_ready),
		.pop_job     (back_job),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_value   (out_value),
		.out_present (m_tuser),
		.out_width   (out_width)
	);

	assign m_tdata = {out_width, out_value};

endmodule
`default_nettype wire
